/* rtl/core/nac_pkg.sv */
// Shared types and constants for the neighbor address cache.
// Used by the cell, the controller and the top level; no dependencies.
package nac_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_W       = 32;
    localparam int STATION_W   = 48;

    // Request kinds
    localparam logic REQ_LEARN  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [KEY_W-1:0]     t_key;
    typedef logic [STATION_W-1:0] t_station;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RES  = 2'b10
    } t_state;

    // Broadcast from the controller to every cell of the row
    typedef struct packed {
        logic     capture;
        t_key     cmp_key;
        t_key     wr_key;
        t_station wr_station;
    } t_cell_ctrl;

endpackage

/* rtl/core/nac_cell.sv */
// One table entry: stored key and station word plus registered compare flags.
// Depends on nac_pkg.
module nac_cell
    import nac_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_wr_en,
    output logic       o_match,
    output logic       o_empty,
    output t_station   o_station
);

    t_key     r_key;
    t_station r_station;
    logic     r_match;
    logic     r_empty;
    logic     n_match;
    logic     n_empty;

    // Compare against the entry as it stands after a write in this same cycle
    always_comb begin
        n_match = r_match;
        n_empty = r_empty;
        if (i_ctrl.capture) begin
            if (i_wr_en) begin
                n_match = (i_ctrl.wr_key == i_ctrl.cmp_key);
                n_empty = 1'b0;
            end else begin
                n_match = (r_key == i_ctrl.cmp_key);
                n_empty = (r_key == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_match <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_match <= n_match;
            r_empty <= n_empty;
            if (i_wr_en) begin
                r_key <= i_ctrl.wr_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_station <= i_ctrl.wr_station;
        end
    end

    assign o_match   = r_match;
    assign o_empty   = r_empty;
    assign o_station = r_station;

endmodule

/* rtl/core/nac_ctrl.sv */
// Request handshake, first-entry resolution, table write and result register.
// Depends on nac_pkg; drives the row of nac_cell instances.
module nac_ctrl
    import nac_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_req_type,
    input  t_key                   i_key_address,
    input  t_station               i_station_address,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_hit,
    output t_station               o_found_station,
    output logic                   o_status,
    output t_cell_ctrl             o_cell_ctrl,
    output logic [TABLE_DEPTH-1:0] o_wr_en,
    input  logic [TABLE_DEPTH-1:0] i_match,
    input  logic [TABLE_DEPTH-1:0] i_empty,
    input  t_station               i_station [TABLE_DEPTH]
);

    t_state   r_state, n_state;
    logic     r_kind;
    t_key     r_key;
    t_station r_station;
    logic     r_out_valid, n_out_valid;
    logic     r_hit;
    t_station r_found;
    logic     r_status;

    logic                   out_free;
    logic                   accept;
    logic                   complete;
    logic                   key_zero;
    logic [TABLE_DEPTH-1:0] scan_vec;
    logic [TABLE_DEPTH-1:0] first;
    logic                   res_hit;
    t_station               res_found;
    logic                   res_status;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign complete   = (r_state == ST_RES) && out_free;
    assign o_in_stall = !((r_state == ST_IDLE) || complete);
    assign accept     = i_in_valid && !o_in_stall;
    assign key_zero   = (r_key == '0);

    // Isolate the lowest set bit: first entry that ends the scan
    assign scan_vec = (r_kind == REQ_LEARN) ? (i_match | i_empty) : i_match;
    assign first    = scan_vec & (~scan_vec + TABLE_DEPTH'(1));

    always_comb begin
        res_found = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (first[i]) begin
                res_found = res_found | i_station[i];
            end
        end
        res_hit    = 1'b0;
        res_status = STATUS_OK;
        if (key_zero) begin
            res_found = '0;
        end else if (r_kind == REQ_LEARN) begin
            res_found  = '0;
            res_hit    = |(first & i_match);
            res_status = (first == '0) ? STATUS_FULL : STATUS_OK;
        end else begin
            res_hit = |first;
        end
    end

    assign o_wr_en = (complete && (r_kind == REQ_LEARN) && !key_zero)
                   ? (first & i_empty) : '0;

    assign o_cell_ctrl.capture    = accept;
    assign o_cell_ctrl.cmp_key    = i_key_address;
    assign o_cell_ctrl.wr_key     = r_key;
    assign o_cell_ctrl.wr_station = r_station;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (complete && !accept) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (complete) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_req_type;
            r_key     <= i_key_address;
            r_station <= i_station_address;
        end
        if (complete) begin
            r_hit    <= res_hit;
            r_found  <= res_found;
            r_status <= res_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_found_station = r_found;
    assign o_status        = r_status;

`ifndef SYNTHESIS
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_wr_en))
        else $error("more than one entry written");
    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (complete && res_status == STATUS_FULL) |-> (o_wr_en == '0))
        else $error("write on full table");
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == STATUS_FULL) |-> !r_hit)
        else $error("full status with hit");
    a_complete_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        complete |=> r_out_valid)
        else $error("result not registered");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_in_stall)
        else $error("stall while idle");
`endif

endmodule

/* rtl/core/neighbor_address_cache_top.sv */
// Neighbor address cache: maps 32-bit network addresses to 48-bit station
// addresses in a row of TABLE_DEPTH entry cells and a controller; uses nac_pkg.
//
// A request is taken at an edge where i_in_valid is high and o_in_stall low.
// At the accept edge every cell compares the key against its entry and
// registers match and empty flags. Once the result register is free, the
// controller picks the lowest flagged entry, writes a nonzero learn key into
// it if it was empty and loads the result register; the flag register is
// followed by the priority pick. A new request is taken at the edge that
// loads the result, so while the output flows the block takes one request
// per cycle. The result register holds a word while the output is stalled.
// The request behind it then waits with its flags held, and the input
// stalls. The table comes out of reset empty with no clearing pass.
module neighbor_address_cache_top
    import nac_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  logic     i_req_type,
    input  t_key     i_key_address,
    input  t_station i_station_address,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output logic     o_hit,
    output t_station o_found_station,
    output logic     o_status
);

    t_cell_ctrl             cell_ctrl;
    logic [TABLE_DEPTH-1:0] wr_en;
    logic [TABLE_DEPTH-1:0] match;
    logic [TABLE_DEPTH-1:0] empty;
    t_station               station [TABLE_DEPTH];

    nac_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_key_address     (i_key_address),
        .i_station_address (i_station_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hit             (o_hit),
        .o_found_station   (o_found_station),
        .o_status          (o_status),
        .o_cell_ctrl       (cell_ctrl),
        .o_wr_en           (wr_en),
        .i_match           (match),
        .i_empty           (empty),
        .i_station         (station)
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        nac_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (cell_ctrl),
            .i_wr_en   (wr_en[g]),
            .o_match   (match[g]),
            .o_empty   (empty[g]),
            .o_station (station[g])
        );
    end

endmodule

/* sim/nac_scoreboard_pkg.sv */
// Scoreboard for the neighbor address cache testbench: a shadow copy of the
// neighbor table that predicts each answer word and checks the DUT against it.
// Depends on nac_pkg for widths, request kinds and status codes.
`timescale 1ns / 100ps
package nac_scoreboard_pkg;
    import nac_pkg::*;

    typedef struct packed {
        logic     hit;
        t_station found;
        logic     status;
    } t_answer;

    class neighbor_table_shadow;
        t_key     keys[TABLE_DEPTH];
        t_station stations[TABLE_DEPTH];
        t_answer  pending_answers[$];
        int       mismatches;
        int       learns;
        int       known_learns;
        int       full_learns;
        int       lookups;
        int       lookup_hits;

        function new();
            foreach (keys[i]) begin
                keys[i]     = '0;
                stations[i] = '0;
            end
            mismatches   = 0;
            learns       = 0;
            known_learns = 0;
            full_learns  = 0;
            lookups      = 0;
            lookup_hits  = 0;
        endfunction

        // Apply one accepted request to the shadow table and queue its answer.
        function void take_request(logic kind, t_key key, t_station station);
            t_answer want;
            int      slot;
            want = '0;
            slot = -1;
            if (kind == REQ_LEARN) begin
                learns++;
            end else begin
                lookups++;
            end
            // Key zero marks an empty entry: never stored, never found.
            if (key != '0) begin
                if (kind == REQ_LEARN) begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slot < 0 && (keys[i] == key || keys[i] == '0)) slot = i;
                    end
                    if (slot < 0) begin
                        want.status = STATUS_FULL;
                        full_learns++;
                    end else if (keys[slot] == key) begin
                        // Keep the stored station even if the new one differs.
                        want.hit = 1'b1;
                        known_learns++;
                    end else begin
                        keys[slot]     = key;
                        stations[slot] = station;
                    end
                end else begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (!want.hit && keys[i] == key) begin
                            want.hit   = 1'b1;
                            want.found = stations[i];
                        end
                    end
                    if (want.hit) lookup_hits++;
                end
            end
            pending_answers.push_back(want);
        endfunction

        function void check_answer(logic hit, t_station found, logic status);
            t_answer want;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected answer word: hit %0b station %012h status %0b",
                             hit, found, status);
                end
                return;
            end
            want = pending_answers.pop_front();
            if (want.hit !== hit || want.found !== found || want.status !== status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected hit %0b station %012h status %0b",
                             want.hit, want.found, want.status);
                    $display("          actual   hit %0b station %012h status %0b",
                             hit, found, status);
                end
            end
        endfunction
    endclass

endpackage

/* sim/neighbor_address_cache_top_test.sv */
// Testbench top for neighbor_address_cache_top: directed and random learn and
// lookup words under varying idle and stall patterns, checked by a shadow table.
// Depends on nac_pkg and nac_scoreboard_pkg.
`timescale 1ns / 100ps
module neighbor_address_cache_top_test;
    import nac_pkg::*;
    import nac_scoreboard_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 300;
    localparam int KEY_POOL     = 44;

    logic     i_clk             = 1'b0;
    logic     i_rst_n           = 1'b0;
    logic     i_in_valid        = 1'b0;
    logic     o_in_stall;
    logic     i_req_type        = REQ_LEARN;
    t_key     i_key_address     = '0;
    t_station i_station_address = '0;
    logic     o_out_valid;
    logic     i_out_stall       = 1'b0;
    logic     o_hit;
    t_station o_found_station;
    logic     o_status;

    neighbor_table_shadow shadow;
    int   sender_idle_pct   = 7;
    int   receiver_idle_pct = 60;
    int   quiet_cycles      = 0;
    t_key key_pool[KEY_POOL];

    neighbor_address_cache_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_key_address     (i_key_address),
        .i_station_address (i_station_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hit             (o_hit),
        .o_found_station   (o_found_station),
        .o_status          (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            shadow.check_answer(o_hit, o_found_station, o_status);
        end
    end

    // Count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_request(input logic kind, input t_key key, input t_station station);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_req_type        <= kind;
        i_key_address     <= key;
        i_station_address <= station;
        // Hold the word until the DUT takes it.
        do @(posedge i_clk); while (o_in_stall);
        shadow.take_request(kind, key, station);
    endtask

    task automatic send_random_request();
        logic     kind;
        t_key     key;
        t_station station;
        int       pick;
        kind    = 1'($urandom_range(1));
        station = t_station'({$urandom(), $urandom()});
        pick    = $urandom_range(99);
        if (pick < 8) begin
            key = '0;
        end else if (pick < 25) begin
            key = $urandom();
        end else begin
            key = key_pool[$urandom_range(KEY_POOL - 1)];
        end
        send_request(kind, key, station);
    endtask

    initial begin
        shadow = new();
        // A pool larger than the table, so it fills and then refuses new keys.
        foreach (key_pool[i]) begin
            key_pool[i] = $urandom();
            if (key_pool[i] == '0) key_pool[i] = t_key'(i + 1);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 7  : (phase == 1) ? 60 : 0;
            receiver_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 7  : 0;
            if (phase == 0) begin
                // Empty table, reserved key zero, field extremes, relearn keeps station.
                send_request(REQ_LOOKUP, 32'h0000_0001, '0);
                send_request(REQ_LEARN,  32'h0000_0000, 48'hFFFF_FFFF_FFFF);
                send_request(REQ_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
                send_request(REQ_LEARN,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
                send_request(REQ_LEARN,  32'h0000_0001, 48'h0000_0000_0000);
                send_request(REQ_LEARN,  32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A);
                send_request(REQ_LEARN,  32'h5A5A_5A5A, 48'hA5A5_A5A5_A5A5);
                send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
                send_request(REQ_LOOKUP, 32'h0000_0001, '0);
                send_request(REQ_LEARN,  32'hFFFF_FFFF, 48'h1234_5678_9ABC);
                send_request(REQ_LOOKUP, 32'hFFFF_FFFF, '0);
                send_request(REQ_LOOKUP, 32'hA5A5_A5A5, '0);
                send_request(REQ_LOOKUP, 32'h5A5A_5A5A, '0);
                send_request(REQ_LOOKUP, 32'h8000_0000, '0);
                send_request(REQ_LEARN,  32'h0000_0001, 48'hFFFF_FFFF_FFFF);
                send_request(REQ_LOOKUP, 32'h0000_0001, 48'hFFFF_FFFF_FFFF);
            end
            repeat (PHASE_ITEMS) send_random_request();
        end
        i_in_valid <= 1'b0;

        while (shadow.pending_answers.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("Sent %0d learns (%0d already known, %0d refused as full)",
                 shadow.learns, shadow.known_learns, shadow.full_learns);
        $display("and %0d lookups (%0d hits) under three idle/stall mixes.",
                 shadow.lookups, shadow.lookup_hits);
        if (shadow.mismatches == 0 && shadow.pending_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatched answer words", shadow.mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
